// ===== rtl/hsvtl_pkg.sv =====
// Shared types and constants of the HSV traffic light classifier.
`timescale 1ns / 1ps
`default_nettype none

package hsvtl_pkg;

  // Pixel component, hue/saturation and counter widths
  localparam int unsigned PixW = 8;
  localparam int unsigned CntW = 18;

  // Divider operand widths: dividend below 2^17, divisor 2*max or 2*d
  localparam int unsigned DivdW = 17;
  localparam int unsigned DvsrW = 9;
  localparam int unsigned QuotW = 8;

  // Largest pixel count a region may hold, and the counter ceiling
  localparam int unsigned MaxPixels = 131072;
  localparam int unsigned CntFieldMax = (2 ** CntW) - 1;
  localparam int unsigned CntCapInt = (MaxPixels < CntFieldMax) ? MaxPixels : CntFieldMax;
  localparam logic [CntW-1:0] CntCap = CntW'(CntCapInt);

  // Register reset values
  localparam logic [PixW-1:0] RstRedLowHi  = 8'd10;
  localparam logic [PixW-1:0] RstRedHighLo = 8'd170;
  localparam logic [PixW-1:0] RstYelLo     = 8'd20;
  localparam logic [PixW-1:0] RstYelHi     = 8'd30;
  localparam logic [PixW-1:0] RstGrnLo     = 8'd40;
  localparam logic [PixW-1:0] RstGrnHi     = 8'd80;
  localparam logic [PixW-1:0] RstSatMin    = 8'd100;
  localparam logic [PixW-1:0] RstValMin    = 8'd100;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_RED_LOW_HUE_HIGH = 3'd0,
    CFG_RED_HIGH_HUE_LOW = 3'd1,
    CFG_YELLOW_HUE_LOW   = 3'd2,
    CFG_YELLOW_HUE_HIGH  = 3'd3,
    CFG_GREEN_HUE_LOW    = 3'd4,
    CFG_GREEN_HUE_HIGH   = 3'd5,
    CFG_SATURATION_MIN   = 3'd6,
    CFG_VALUE_MIN        = 3'd7
  } cfg_idx_e;

  // Colour verdict codes
  typedef enum logic [1:0] {
    COL_UNKNOWN = 2'd0,
    COL_RED     = 2'd1,
    COL_YELLOW  = 2'd2,
    COL_GREEN   = 2'd3
  } color_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SDIV,
    ST_HPREP,
    ST_HDIV,
    ST_CLASS
  } state_e;

  // Divider control from the sequencer
  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/hsvtl_div.sv =====
// Shared restoring divider, one quotient bit per step, eight steps.
`timescale 1ns / 1ps
`default_nettype none

module hsvtl_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire hsvtl_pkg::div_ctrl_t        ctrl_i,
  input  wire logic [hsvtl_pkg::DivdW-1:0] dividend_i,
  input  wire logic [hsvtl_pkg::DvsrW-1:0] divisor_i,
  output logic      [hsvtl_pkg::QuotW-1:0] quot_o,
  output logic                             last_o
);

  logic [hsvtl_pkg::DivdW-1:0] rem_q, rem_d;
  logic [hsvtl_pkg::DivdW-1:0] trial_q, trial_d;
  logic [hsvtl_pkg::QuotW-1:0] quot_q, quot_d;
  logic [2:0]                  cnt_q, cnt_d;

  // Divisor starts shifted to the top quotient bit and walks down
  always_comb begin
    rem_d   = rem_q;
    trial_d = trial_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    if (ctrl_i.load) begin
      rem_d   = dividend_i;
      trial_d = {1'b0, divisor_i, 7'b0};
      quot_d  = '0;
      cnt_d   = 3'd7;
    end else if (ctrl_i.step) begin
      if (rem_q >= trial_q) begin
        rem_d  = rem_q - trial_q;
        quot_d = {quot_q[hsvtl_pkg::QuotW-2:0], 1'b1};
      end else begin
        quot_d = {quot_q[hsvtl_pkg::QuotW-2:0], 1'b0};
      end
      trial_d = {1'b0, trial_q[hsvtl_pkg::DivdW-1:1]};
      cnt_d   = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    trial_q <= trial_d;
    quot_q  <= quot_d;
  end

  assign quot_o = quot_q;
  assign last_o = (cnt_q == 3'd0);

endmodule

`default_nettype wire

// ===== rtl/hsv_traffic_light_classifier_top.sv =====
// Top level of the HSV traffic light classifier: sequencer, counters, config.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------------
//  pixel   | in        | in_valid_i / in_stall_o   | blue_i, green_in_i, red_in_i, last_pixel_i
//  result  | out       | out_valid_o / out_stall_i | color_o, red/yellow/green_total_o
//  config  | in        | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// Each pixel passes through accept, a set-up state, eight divider steps for
// saturation, a set-up state, eight divider steps for hue and a classify state.
// The single shared divider serves both; in_stall_o is high in every state but idle.
// A result sits in an output register, so pixels keep flowing while it waits; only
// a further last pixel holds in the classify state until the register is free.
// Reset restores the register defaults and clears the counters and output valid.
`timescale 1ns / 1ps
`default_nettype none

module hsv_traffic_light_classifier_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // pixel channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  blue_i,
  input  wire logic [7:0]  green_in_i,
  input  wire logic [7:0]  red_in_i,
  input  wire logic        last_pixel_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       color_o,
  output logic [17:0]      red_total_o,
  output logic [17:0]      yellow_total_o,
  output logic [17:0]      green_total_o,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  localparam int unsigned PW = hsvtl_pkg::PixW;
  localparam int unsigned CW = hsvtl_pkg::CntW;

  hsvtl_pkg::state_e state_q, state_d;

  // configuration registers
  logic [PW-1:0] red_lo_hi_q, red_hi_lo_q, yel_lo_q, yel_hi_q;
  logic [PW-1:0] grn_lo_q, grn_hi_q, sat_min_q, val_min_q;

  // pixel and intermediate registers
  logic [PW-1:0] blue_q, green_q, red_q;
  logic          last_q;
  logic [PW-1:0] mx_q, d_q, sat_q;
  logic [10:0]   x_q;

  // counters and result
  logic [CW-1:0] red_cnt_q, yel_cnt_q, grn_cnt_q;
  logic [CW-1:0] red_cnt_d, yel_cnt_d, grn_cnt_d;
  logic          out_valid_q;
  logic [1:0]    color_q;
  logic [CW-1:0] red_tot_q, yel_tot_q, grn_tot_q;
  hsvtl_pkg::color_e color_w;

  // sequencer outputs
  logic                 in_accept;
  logic                 out_accept;
  logic                 hold_w;
  logic                 cls_en;
  logic                 out_load;
  hsvtl_pkg::div_ctrl_t div_ctrl;
  logic [hsvtl_pkg::DivdW-1:0] div_dividend;
  logic [hsvtl_pkg::DvsrW-1:0] div_divisor;
  logic [hsvtl_pkg::QuotW-1:0] div_quot;
  logic                        div_last;

  // combinational pixel maths
  logic [PW-1:0]      mx_w, mn_w, d_w;
  logic signed [11:0] x_raw, d2_s, d4_s;
  logic [10:0]        x_w;
  logic [PW-1:0]      hue_w;
  logic               colored_w;
  logic               is_red, is_yel, is_grn;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;
  assign hold_w     = last_q && out_valid_q && out_stall_i;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_lo_hi_q <= hsvtl_pkg::RstRedLowHi;
      red_hi_lo_q <= hsvtl_pkg::RstRedHighLo;
      yel_lo_q    <= hsvtl_pkg::RstYelLo;
      yel_hi_q    <= hsvtl_pkg::RstYelHi;
      grn_lo_q    <= hsvtl_pkg::RstGrnLo;
      grn_hi_q    <= hsvtl_pkg::RstGrnHi;
      sat_min_q   <= hsvtl_pkg::RstSatMin;
      val_min_q   <= hsvtl_pkg::RstValMin;
    end else if (cfg_we_i) begin
      case (hsvtl_pkg::cfg_idx_e'(cfg_index_i))
        hsvtl_pkg::CFG_RED_LOW_HUE_HIGH: red_lo_hi_q <= cfg_data_i;
        hsvtl_pkg::CFG_RED_HIGH_HUE_LOW: red_hi_lo_q <= cfg_data_i;
        hsvtl_pkg::CFG_YELLOW_HUE_LOW:   yel_lo_q    <= cfg_data_i;
        hsvtl_pkg::CFG_YELLOW_HUE_HIGH:  yel_hi_q    <= cfg_data_i;
        hsvtl_pkg::CFG_GREEN_HUE_LOW:    grn_lo_q    <= cfg_data_i;
        hsvtl_pkg::CFG_GREEN_HUE_HIGH:   grn_hi_q    <= cfg_data_i;
        hsvtl_pkg::CFG_SATURATION_MIN:   sat_min_q   <= cfg_data_i;
        hsvtl_pkg::CFG_VALUE_MIN:        val_min_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Max, min and hue sixth; red wins ties, then green
  always_comb begin
    mx_w = red_q;
    mn_w = red_q;
    if (green_q > mx_w) mx_w = green_q;
    if (blue_q > mx_w) mx_w = blue_q;
    if (green_q < mn_w) mn_w = green_q;
    if (blue_q < mn_w) mn_w = blue_q;
    d_w  = mx_w - mn_w;
    d2_s = $signed({3'b0, d_w, 1'b0});
    d4_s = $signed({2'b0, d_w, 2'b0});
    if (mx_w == red_q) begin
      x_raw = $signed({4'b0, green_q}) - $signed({4'b0, blue_q});
    end else if (mx_w == green_q) begin
      x_raw = $signed({4'b0, blue_q}) - $signed({4'b0, red_q}) + d2_s;
    end else begin
      x_raw = $signed({4'b0, red_q}) - $signed({4'b0, green_q}) + d4_s;
    end
    if (x_raw < 0) begin
      x_raw = x_raw + d4_s + d2_s;
    end
    x_w = x_raw[10:0];
  end

  // Divider operands: 510*d + V over 2V, then 60*x + d over 2d
  always_comb begin
    if (state_q == hsvtl_pkg::ST_PREP) begin
      div_dividend = {d_w, 9'b0} - {8'b0, d_w, 1'b0} + {9'b0, mx_w};
      div_divisor  = {mx_w, 1'b0};
    end else begin
      div_dividend = {x_q, 6'b0} - {4'b0, x_q, 2'b0} + {9'b0, d_q};
      div_divisor  = {d_q, 1'b0};
    end
  end

  hsvtl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (div_quot),
    .last_o     (div_last)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hsvtl_pkg::ST_IDLE:  if (in_accept) state_d = hsvtl_pkg::ST_PREP;
      hsvtl_pkg::ST_PREP:  state_d = hsvtl_pkg::ST_SDIV;
      hsvtl_pkg::ST_SDIV:  if (div_last) state_d = hsvtl_pkg::ST_HPREP;
      hsvtl_pkg::ST_HPREP: state_d = hsvtl_pkg::ST_HDIV;
      hsvtl_pkg::ST_HDIV:  if (div_last) state_d = hsvtl_pkg::ST_CLASS;
      hsvtl_pkg::ST_CLASS: if (!hold_w) state_d = hsvtl_pkg::ST_IDLE;
      default:             state_d = hsvtl_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o    = 1'b1;
    div_ctrl.load = 1'b0;
    div_ctrl.step = 1'b0;
    cls_en        = 1'b0;
    case (state_q)
      hsvtl_pkg::ST_IDLE:  in_stall_o = 1'b0;
      hsvtl_pkg::ST_PREP:  div_ctrl.load = 1'b1;
      hsvtl_pkg::ST_SDIV:  div_ctrl.step = 1'b1;
      hsvtl_pkg::ST_HPREP: div_ctrl.load = 1'b1;
      hsvtl_pkg::ST_HDIV:  div_ctrl.step = 1'b1;
      hsvtl_pkg::ST_CLASS: cls_en = !hold_w;
      default:             in_stall_o = 1'b1;
    endcase
  end

  assign out_load = cls_en && last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hsvtl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Pixel capture and intermediates
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      blue_q  <= blue_i;
      green_q <= green_in_i;
      red_q   <= red_in_i;
      last_q  <= last_pixel_i;
    end
    if (state_q == hsvtl_pkg::ST_PREP) begin
      mx_q <= mx_w;
      d_q  <= d_w;
      x_q  <= x_w;
    end
    // black pixel has no saturation
    if (state_q == hsvtl_pkg::ST_HPREP) begin
      sat_q <= (mx_q == '0) ? '0 : div_quot;
    end
  end

  // Classification; grey has hue 0
  always_comb begin
    hue_w     = (d_q == '0) ? '0 : div_quot;
    colored_w = (sat_q >= sat_min_q) && (mx_q >= val_min_q);
    is_red    = colored_w && ((hue_w <= red_lo_hi_q) || (hue_w >= red_hi_lo_q));
    is_yel    = colored_w && (hue_w >= yel_lo_q) && (hue_w <= yel_hi_q);
    is_grn    = colored_w && (hue_w >= grn_lo_q) && (hue_w <= grn_hi_q);
    red_cnt_d = red_cnt_q;
    yel_cnt_d = yel_cnt_q;
    grn_cnt_d = grn_cnt_q;
    if (is_red && (red_cnt_q < hsvtl_pkg::CntCap)) red_cnt_d = red_cnt_q + 1'b1;
    if (is_yel && (yel_cnt_q < hsvtl_pkg::CntCap)) yel_cnt_d = yel_cnt_q + 1'b1;
    if (is_grn && (grn_cnt_q < hsvtl_pkg::CntCap)) grn_cnt_d = grn_cnt_q + 1'b1;
  end

  // Strictly largest count wins, else unknown
  always_comb begin
    if ((red_cnt_d > yel_cnt_d) && (red_cnt_d > grn_cnt_d)) begin
      color_w = hsvtl_pkg::COL_RED;
    end else if ((yel_cnt_d > red_cnt_d) && (yel_cnt_d > grn_cnt_d)) begin
      color_w = hsvtl_pkg::COL_YELLOW;
    end else if ((grn_cnt_d > red_cnt_d) && (grn_cnt_d > yel_cnt_d)) begin
      color_w = hsvtl_pkg::COL_GREEN;
    end else begin
      color_w = hsvtl_pkg::COL_UNKNOWN;
    end
  end

  // Counters: bump on classify, clear after the last pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_cnt_q <= '0;
      yel_cnt_q <= '0;
      grn_cnt_q <= '0;
    end else if (out_load) begin
      red_cnt_q <= '0;
      yel_cnt_q <= '0;
      grn_cnt_q <= '0;
    end else if (cls_en) begin
      red_cnt_q <= red_cnt_d;
      yel_cnt_q <= yel_cnt_d;
      grn_cnt_q <= grn_cnt_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_accept) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      color_q   <= color_w;
      red_tot_q <= red_cnt_d;
      yel_tot_q <= yel_cnt_d;
      grn_tot_q <= grn_cnt_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign color_o        = color_q;
  assign red_total_o    = red_tot_q;
  assign yellow_total_o = yel_tot_q;
  assign green_total_o  = grn_tot_q;

  // Assertions
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == hsvtl_pkg::ST_PREP))
    else $error("accepted pixel did not start the sequence");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hsvtl_pkg::ST_CLASS) |-> (hue_w <= 8'd180))
    else $error("hue beyond 180");

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (red_cnt_q <= hsvtl_pkg::CntCap) && (yel_cnt_q <= hsvtl_pkg::CntCap)
      && (grn_cnt_q <= hsvtl_pkg::CntCap))
    else $error("counter above its ceiling");

  a_result_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && (red_cnt_q == '0) && (yel_cnt_q == '0)
      && (grn_cnt_q == '0)))
    else $error("result load did not clear the counters");

endmodule

`default_nettype wire
